// ===== rtl/core/bwae_pkg.sv =====
// bwae_pkg.sv - shared types and constants of the black/white alpha extractor
`timescale 1ns / 1ps

package bwae_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int NUM_W       = 2 * CHAN_W;        // dark * 255
    localparam int SUM_W       = CHAN_W + 2;        // sum of three coverages
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;   // 2^24 / 1 needs one more bit
    localparam int DIV3_SHIFT  = 11;
    localparam int REM_W       = CHAN_W + 1;        // remainder stays below 2 * coverage

    localparam logic [SUM_W-1:0]  DIV3_MUL = SUM_W'(683);   // ceil(2^11 / 3)
    localparam logic [NUM_W-1:0]  ROUND    = NUM_W'(128);
    localparam logic [CHAN_W-1:0] OPAQUE   = CHAN_W'(255);

    typedef struct packed {
        logic [CHAN_W-1:0] dark_red;
        logic [CHAN_W-1:0] dark_green;
        logic [CHAN_W-1:0] dark_blue;
        logic [CHAN_W-1:0] light_red;
        logic [CHAN_W-1:0] light_green;
        logic [CHAN_W-1:0] light_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_alpha;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } pixel_out_t;

endpackage

// ===== rtl/core/black_white_alpha_extract_top.sv =====
// black_white_alpha_extract_top.sv - pipelined difference-matting alpha extractor
//
// s_valid/s_ready/s_data: one pixel per transfer, rendered over dark and light.
// m_valid/m_ready/m_data: one result per pixel, alpha and premultiplied rgb.
// cfg_valid/cfg_ready/cfg_data: writes use_alpha; cfg_ready is always high.
// Five register stages: coverage and alpha sum, reciprocal multiply and alpha
// divide-by-three, remainder, quotient correction, premultiply into the
// output register. A result shows on m_valid once it reaches that register.
// Throughput is one pixel per cycle while m_ready is high, fully pipelined.
// Each stage moves when the stage after it is empty or moving, so a stall on
// m_ready fills the bubbles first and then holds s_ready low; nothing is
// lost or repeated. Reset empties the pipeline and clears use_alpha to 0
// (dark pixel passed through with alpha 255).
`timescale 1ns / 1ps

module black_white_alpha_extract_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bwae_pkg::pixel_in_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bwae_pkg::pixel_out_t  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);

    localparam int CW = bwae_pkg::CHAN_W;
    localparam int NC = bwae_pkg::NUM_CHAN;
    localparam int NW = bwae_pkg::NUM_W;
    localparam int SW = bwae_pkg::SUM_W;
    localparam int RW = bwae_pkg::RECIP_W;
    localparam int MW = bwae_pkg::REM_W;

    // reciprocal table, floor(2^24 / c), worked out at elaboration
    logic [RW-1:0] recip_tbl [2**CW];

    for (genvar gi = 0; gi < 2**CW; gi++) begin : g_recip
        if (gi == 0) begin : g_zero
            assign recip_tbl[gi] = '0;
        end else begin : g_val
            localparam logic [RW-1:0] RECIP_VAL =
                RW'((64'd1 << bwae_pkg::RECIP_SHIFT) / gi);
            assign recip_tbl[gi] = RECIP_VAL;
        end
    end

    logic use_alpha_reg;

    // stage valid bits and per-stage enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // stage 1
    logic [CW-1:0] s1_dark_reg [NC];
    logic [CW-1:0] s1_cov_reg  [NC];
    logic [NW-1:0] s1_num_reg  [NC];
    logic [SW-1:0] s1_sum_reg;
    logic          s1_mode_reg;
    // stage 2
    logic [CW-1:0] s2_dark_reg [NC];
    logic [CW-1:0] s2_cov_reg  [NC];
    logic [NW-1:0] s2_num_reg  [NC];
    logic [NW-1:0] s2_qest_reg [NC];
    logic [CW-1:0] s2_alpha_reg;
    logic          s2_mode_reg;
    // stage 3
    logic [CW-1:0] s3_dark_reg [NC];
    logic [CW-1:0] s3_cov_reg  [NC];
    logic [CW-1:0] s3_qlo_reg  [NC];
    logic [MW-1:0] s3_rem_reg  [NC];
    logic [CW-1:0] s3_alpha_reg;
    logic          s3_mode_reg;
    // stage 4
    logic [CW-1:0] s4_dark_reg [NC];
    logic [CW-1:0] s4_chan_reg [NC];
    logic [CW-1:0] s4_alpha_reg;
    logic          s4_mode_reg;
    // output
    bwae_pkg::pixel_out_t out_reg;

    logic [CW-1:0] in_dark  [NC];
    logic [CW-1:0] in_light [NC];
    logic [CW-1:0] cov_next [NC];
    logic [NW-1:0] num_next [NC];
    logic [SW-1:0] sum_next;
    logic [NW-1:0] qest_next [NC];
    logic [CW-1:0] alpha_next;
    logic [MW-1:0] rem_next  [NC];
    logic [CW-1:0] chan_next [NC];
    logic [CW-1:0] prem_next [NC];
    bwae_pkg::pixel_out_t out_next;

    assign cfg_ready = 1'b1;

    assign en5     = !v5_reg || m_ready;
    assign en4     = !v4_reg || en5;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v5_reg;
    assign m_data  = out_reg;

    assign in_dark[0]  = s_data.dark_red;
    assign in_dark[1]  = s_data.dark_green;
    assign in_dark[2]  = s_data.dark_blue;
    assign in_light[0] = s_data.light_red;
    assign in_light[1] = s_data.light_green;
    assign in_light[2] = s_data.light_blue;

    // stage 1: coverage, dividend dark * 255, coverage sum
    always_comb begin
        sum_next = '0;
        for (int k = 0; k < NC; k++) begin
            cov_next[k] = bwae_pkg::OPAQUE - in_light[k] + in_dark[k];
            num_next[k] = {in_dark[k], CW'(0)} - NW'(in_dark[k]);
            sum_next    = sum_next + SW'(cov_next[k]);
        end
    end

    // stage 2: quotient estimate (exact or one low), alpha = sum / 3
    always_comb begin
        logic [2*SW-1:0] a_prod;
        logic [NW+RW-1:0] q_prod;
        a_prod     = (2*SW)'(s1_sum_reg) * (2*SW)'(bwae_pkg::DIV3_MUL);
        alpha_next = CW'(a_prod >> bwae_pkg::DIV3_SHIFT);
        for (int k = 0; k < NC; k++) begin
            q_prod       = (NW+RW)'(s1_num_reg[k]) * (NW+RW)'(recip_tbl[s1_cov_reg[k]]);
            qest_next[k] = NW'(q_prod >> bwae_pkg::RECIP_SHIFT);
        end
    end

    // stage 3: remainder of the estimate
    always_comb begin
        logic [NW+CW-1:0] r_full;
        for (int k = 0; k < NC; k++) begin
            r_full      = (NW+CW)'(s2_num_reg[k])
                        - (NW+CW)'(s2_qest_reg[k]) * (NW+CW)'(s2_cov_reg[k]);
            rem_next[k] = MW'(r_full);
        end
    end

    // stage 4: correct quotient, zero coverage passes dark through
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            if (s3_cov_reg[k] == '0) begin
                chan_next[k] = s3_dark_reg[k];
            end else if (s3_rem_reg[k] >= MW'(s3_cov_reg[k])) begin
                chan_next[k] = s3_qlo_reg[k] + CW'(1);
            end else begin
                chan_next[k] = s3_qlo_reg[k];
            end
        end
    end

    // stage 5: premultiply with rounding, or pass dark through with alpha 255
    always_comb begin
        logic [NW-1:0] p;
        for (int k = 0; k < NC; k++) begin
            p            = NW'(s4_chan_reg[k]) * NW'(s4_alpha_reg) + bwae_pkg::ROUND;
            prem_next[k] = p[NW-1:CW];
        end
        if (s4_mode_reg) begin
            out_next.out_alpha = s4_alpha_reg;
            out_next.out_red   = prem_next[0];
            out_next.out_green = prem_next[1];
            out_next.out_blue  = prem_next[2];
        end else begin
            out_next.out_alpha = bwae_pkg::OPAQUE;
            out_next.out_red   = s4_dark_reg[0];
            out_next.out_green = s4_dark_reg[1];
            out_next.out_blue  = s4_dark_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_alpha_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
        end else begin
            if (cfg_valid) begin
                use_alpha_reg <= cfg_data;
            end
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_sum_reg  <= sum_next;
            s1_mode_reg <= use_alpha_reg;
            for (int k = 0; k < NC; k++) begin
                s1_dark_reg[k] <= in_dark[k];
                s1_cov_reg[k]  <= cov_next[k];
                s1_num_reg[k]  <= num_next[k];
            end
        end
        if (en2) begin
            s2_alpha_reg <= alpha_next;
            s2_mode_reg  <= s1_mode_reg;
            for (int k = 0; k < NC; k++) begin
                s2_dark_reg[k] <= s1_dark_reg[k];
                s2_cov_reg[k]  <= s1_cov_reg[k];
                s2_num_reg[k]  <= s1_num_reg[k];
                s2_qest_reg[k] <= qest_next[k];
            end
        end
        if (en3) begin
            s3_alpha_reg <= s2_alpha_reg;
            s3_mode_reg  <= s2_mode_reg;
            for (int k = 0; k < NC; k++) begin
                s3_dark_reg[k] <= s2_dark_reg[k];
                s3_cov_reg[k]  <= s2_cov_reg[k];
                s3_qlo_reg[k]  <= s2_qest_reg[k][CW-1:0];
                s3_rem_reg[k]  <= rem_next[k];
            end
        end
        if (en4) begin
            s4_alpha_reg <= s3_alpha_reg;
            s4_mode_reg  <= s3_mode_reg;
            for (int k = 0; k < NC; k++) begin
                s4_dark_reg[k] <= s3_dark_reg[k];
                s4_chan_reg[k] <= chan_next[k];
            end
        end
        if (en5) begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== rtl/core/bwae_checker.sv =====
// bwae_checker.sv - port-level assertions for the alpha extractor, bound to the top
`timescale 1ns / 1ps

module bwae_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input bwae_pkg::pixel_out_t  m_data
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // an empty output stage means every stage can move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with output stage empty");

    // with m_ready held high a transfer is seen at the output once it has passed every stage
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid)
        else $error("result missing after pipeline latency");

endmodule

bind black_white_alpha_extract_top bwae_checker u_bwae_checker (.*);

// ===== tb/tb_black_white_alpha_extract_top.sv =====
// tb_black_white_alpha_extract_top.sv - self-checking testbench of the alpha extractor
`timescale 1ns / 1ps

module tb_black_white_alpha_extract_top;

    localparam int LONG_HOLD = 60;
    localparam int SETTLE    = 12;

    logic                 aclk    = 1'b0;
    logic                 aresetn;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    bwae_pkg::pixel_in_t  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    bwae_pkg::pixel_out_t m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;

    bwae_pkg::pixel_in_t  pixel_queue[$];
    bwae_pkg::pixel_out_t expected_pixels[$];
    bit         alpha_mode    = 1'b0;   // our copy of use_alpha
    bit         s_fire        = 1'b0;
    bit         cfg_fire      = 1'b0;
    int         src_idle_pct  = 0;
    int         sink_idle_pct = 0;
    int         src_gap       = 0;
    int         sink_gap      = 0;
    int         hold_left     = 0;
    bit         hold_request  = 1'b0;
    int         errors        = 0;

    black_white_alpha_extract_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // unpremultiply by coverage, then premultiply by alpha with rounding
    function automatic logic [7:0] recover_channel(logic [7:0] dark, logic [7:0] cov,
                                                   logic [7:0] alpha);
        int straight;
        if (cov == 8'd0)
            straight = int'(dark);
        else
            straight = ((int'(dark) * 255) / int'(cov)) & 255;
        return 8'((straight * int'(alpha) + 128) >> 8);
    endfunction

    function automatic bwae_pkg::pixel_out_t predict_pixel(bwae_pkg::pixel_in_t px,
                                                           bit use_alpha);
        bwae_pkg::pixel_out_t res;
        logic [7:0] cov_r, cov_g, cov_b, alpha;
        if (!use_alpha) begin
            res.out_alpha = bwae_pkg::OPAQUE;
            res.out_red   = px.dark_red;
            res.out_green = px.dark_green;
            res.out_blue  = px.dark_blue;
            return res;
        end
        cov_r = 8'hFF - px.light_red + px.dark_red;
        cov_g = 8'hFF - px.light_green + px.dark_green;
        cov_b = 8'hFF - px.light_blue + px.dark_blue;
        alpha = 8'((int'(cov_r) + int'(cov_g) + int'(cov_b)) / 3);
        res.out_alpha = alpha;
        res.out_red   = recover_channel(px.dark_red, cov_r, alpha);
        res.out_green = recover_channel(px.dark_green, cov_g, alpha);
        res.out_blue  = recover_channel(px.dark_blue, cov_b, alpha);
        return res;
    endfunction

    // mostly physically plausible dark/light pairs, some noise and near-zero coverage
    function automatic bwae_pkg::pixel_in_t random_pixel();
        bwae_pkg::pixel_in_t px;
        logic [7:0] d[3];
        logic [7:0] l[3];
        int         kind, alpha, c, k;
        kind  = $urandom_range(0, 9);
        alpha = $urandom_range(0, 255);
        for (k = 0; k < 3; k++) begin
            c = $urandom_range(0, 255);
            if (kind < 6) begin
                d[k] = 8'((c * alpha) / 255);
                l[k] = d[k] + 8'(255 - alpha);
                if (kind == 5)
                    l[k] = l[k] + 8'($urandom_range(0, 4)) - 8'd2;
            end else if (kind < 8) begin
                d[k] = 8'($urandom_range(0, 255));
                l[k] = 8'($urandom_range(0, 255));
            end else begin
                d[k] = 8'(c);
                l[k] = d[k] - 8'd1 - 8'($urandom_range(0, 3));
            end
        end
        px.dark_red    = d[0];
        px.dark_green  = d[1];
        px.dark_blue   = d[2];
        px.light_red   = l[0];
        px.light_green = l[1];
        px.light_blue  = l[2];
        return px;
    endfunction

    task automatic push_pixel(logic [7:0] dr, logic [7:0] dg, logic [7:0] db,
                              logic [7:0] lr, logic [7:0] lg, logic [7:0] lb);
        bwae_pkg::pixel_in_t px;
        px.dark_red    = dr;
        px.dark_green  = dg;
        px.dark_blue   = db;
        px.light_red   = lr;
        px.light_green = lg;
        px.light_blue  = lb;
        pixel_queue.push_back(px);
    endtask

    task automatic push_random(int count);
        repeat (count) pixel_queue.push_back(random_pixel());
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // everything sent and every result back, then let the pipeline settle
    task automatic drain();
        while (pixel_queue.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_use_alpha(bit value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(negedge aclk); while (!cfg_fire);
        cfg_valid = 1'b0;
    endtask

    // pixel driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0 && $urandom_range(0, 99) < src_idle_pct) begin
                src_gap = $urandom_range(0, 5);
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                s_data  <= pixel_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with random stalls and an occasional long hold
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on each input transfer, check on each result transfer
    always @(posedge aclk) begin : monitor
        bwae_pkg::pixel_out_t want;
        s_fire   = aresetn && s_valid && s_ready;
        cfg_fire = aresetn && cfg_valid && cfg_ready;
        if (s_fire)
            expected_pixels.push_back(predict_pixel(s_data, alpha_mode));
        if (cfg_fire)
            alpha_mode = cfg_data;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing outstanding", m_data));
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.out_alpha !== want.out_alpha)
                    report_mismatch($sformatf("alpha got %0d want %0d",
                                              m_data.out_alpha, want.out_alpha));
                if (m_data.out_red !== want.out_red)
                    report_mismatch($sformatf("red got %0d want %0d",
                                              m_data.out_red, want.out_red));
                if (m_data.out_green !== want.out_green)
                    report_mismatch($sformatf("green got %0d want %0d",
                                              m_data.out_green, want.out_green));
                if (m_data.out_blue !== want.out_blue)
                    report_mismatch($sformatf("blue got %0d want %0d",
                                              m_data.out_blue, want.out_blue));
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // pass-through mode straight out of reset
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        push_pixel(8'h5A, 8'hA5, 8'h0F, 8'hF0, 8'h33, 8'hCC);
        drain();

        write_use_alpha(1'b1);
        push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);        // zero coverage, black
        push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);  // opaque white
        push_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);              // opaque black
        push_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);        // coverage wraps to 254
        push_pixel(8'd50, 8'd200, 8'd255, 8'd49, 8'd199, 8'd254);    // zero coverage, dark kept
        push_pixel(8'd200, 8'd100, 8'd10, 8'd100, 8'd250, 8'd8);     // quotient overflow
        push_pixel(8'd10, 8'd10, 8'd10, 8'd8, 8'd8, 8'd8);           // coverage of one
        push_pixel(8'd64, 8'd32, 8'd0, 8'd191, 8'd159, 8'd127);      // half coverage
        push_pixel(8'd1, 8'd254, 8'd128, 8'd1, 8'd254, 8'd128);
        push_pixel(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd127);
        push_pixel(8'hAA, 8'h55, 8'hFF, 8'h55, 8'hAA, 8'h00);
        push_pixel(8'h80, 8'h7F, 8'h01, 8'hFF, 8'hFE, 8'hFF);
        push_pixel(8'd100, 8'd100, 8'd100, 8'd255, 8'd255, 8'd255);  // exact 255 quotient
        push_pixel(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
        drain();

        src_idle_pct  = 30;
        sink_idle_pct = 30;
        push_random(400);
        drain();

        write_use_alpha(1'b0);
        src_idle_pct  = 10;
        sink_idle_pct = 40;
        push_random(150);
        drain();

        // long receiver hold while the sender keeps offering
        write_use_alpha(1'b1);
        src_idle_pct  = 5;
        sink_idle_pct = 15;
        hold_request  = 1'b1;
        push_random(300);
        drain();

        // final stretch at full rate, no idling on either side
        write_use_alpha(1'b0);
        write_use_alpha(1'b1);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        push_random(250);
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== black_white_alpha_extract_top.f =====
rtl/core/bwae_pkg.sv
rtl/core/black_white_alpha_extract_top.sv
rtl/core/bwae_checker.sv
tb/tb_black_white_alpha_extract_top.sv
